// ----- rtl/bpa_pkg.sv -----
// buddy page allocator: shared types, sizes and slot arithmetic
// used by every allocator module but the generic bpa_ram; depends on nothing
package bpa_pkg;

  localparam int MAX_BLOCK_ORDER = 10;
  localparam int POOL_PAGES      = 1 << MAX_BLOCK_ORDER;
  localparam int PAGE_W          = MAX_BLOCK_ORDER;
  localparam int COUNT_W         = MAX_BLOCK_ORDER + 1;
  localparam int SLOT_W          = MAX_BLOCK_ORDER + 1;
  localparam int ORD_W           = 4;
  localparam int CFG_W           = 11;
  localparam int ROW_W           = 32;
  localparam int BIT_W           = $clog2(ROW_W);
  localparam int ROW_AW          = SLOT_W - BIT_W;
  localparam int ROWS            = 1 << ROW_AW;
  localparam int ROWS_LEFT_W     = ROW_AW;

  // root of the block tree is slot 1
  localparam logic [SLOT_W-1:0] ROOT_SLOT = SLOT_W'(1);

  // register indexes of the configuration port
  localparam logic CFG_TOTAL_PAGES = 1'b0;
  localparam logic CFG_MAX_REQUEST = 1'b1;

  // item actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_NOMEM   = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef struct packed {
    logic              action;
    logic [ORD_W-1:0]  order;
    logic [PAGE_W-1:0] page_index;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [PAGE_W-1:0]  page_index_res;
    logic [COUNT_W-1:0] free_count;
  } out_item_t;

  // command to the mark store: a range scan or a single bit write
  typedef struct packed {
    logic               valid;
    logic               write;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  count;
    logic               value;
  } mark_cmd_t;

  typedef struct packed {
    logic              ready;
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
  } mark_sts_t;

  // heap slot of the block of order ord that holds page
  function automatic logic [SLOT_W-1:0] slot_of(input logic [ORD_W-1:0] ord,
                                                input logic [PAGE_W-1:0] page);
    logic [SLOT_W-1:0] top;
    top = SLOT_W'(1) << (ORD_W'(MAX_BLOCK_ORDER) - ord);
    return top + SLOT_W'(page >> ord);
  endfunction

endpackage

// ----- rtl/bpa_ram.sv -----
// generic single-write, single-read ram with registered read data
// depends on nothing
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bpa_marks.sv -----
// free mark store: ram of mark rows with a range scan and bit write engine
// depends on bpa_pkg and bpa_ram
module bpa_marks
  import bpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mark_cmd_t cmd,
  output mark_sts_t sts
);

  typedef enum logic [2:0] {
    M_CLEAR,
    M_IDLE,
    M_SCAN_RD,
    M_SCAN_CHK,
    M_WR_RD,
    M_WR_MOD
  } mstate_t;

  mstate_t                state;
  logic [ROW_AW-1:0]      row;
  logic [ROWS_LEFT_W-1:0] rows_left;
  logic [ROW_W-1:0]       mask;
  logic [BIT_W-1:0]       bitsel;
  logic                   value;
  logic                   done;
  logic                   hit;
  logic [SLOT_W-1:0]      hit_slot;

  logic                   we;
  logic [ROW_AW-1:0]      waddr;
  logic [ROW_W-1:0]       wdata;
  logic                   re;
  logic [ROW_W-1:0]       rdata;
  logic [ROW_W-1:0]       masked;
  logic [BIT_W-1:0]       first;
  logic [ROW_W:0]         ones;

  bpa_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(row),
    .rdata(rdata)
  );

  // lowest set mark within the scanned part of the row
  always_comb begin
    masked = rdata & mask;
    first  = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        first = BIT_W'(i);
      end
    end
  end

  // mask for a range that fits inside one row
  assign ones = (ROW_W'(1) << cmd.count[BIT_W:0]) - (ROW_W + 1)'(1);

  // ram write side: clearing pass or read-modify-write
  always_comb begin
    we    = 1'b0;
    waddr = row;
    wdata = rdata;
    re    = (state == M_SCAN_RD) || (state == M_WR_RD);
    if (state == M_CLEAR) begin
      we    = 1'b1;
      wdata = (row == ROOT_SLOT[SLOT_W-1:BIT_W]) ?
              (ROW_W'(1) << ROOT_SLOT[BIT_W-1:0]) : '0;
    end else if (state == M_WR_MOD) begin
      we            = 1'b1;
      wdata[bitsel] = value;
    end
  end

  // engine state and registered status
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_CLEAR;
      row   <= '0;
      done  <= 1'b0;
      hit   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_CLEAR: begin
          row <= row + ROW_AW'(1);
          if (row == ROW_AW'(ROWS - 1)) begin
            state <= M_IDLE;
          end
        end
        M_IDLE: begin
          if (cmd.valid) begin
            row    <= cmd.slot[SLOT_W-1:BIT_W];
            bitsel <= cmd.slot[BIT_W-1:0];
            value  <= cmd.value;
            if (cmd.write) begin
              state <= M_WR_RD;
            end else begin
              state <= M_SCAN_RD;
              if (cmd.count <= SLOT_W'(ROW_W)) begin
                mask      <= ones[ROW_W-1:0] << cmd.slot[BIT_W-1:0];
                rows_left <= ROWS_LEFT_W'(1);
              end else begin
                mask      <= '1;
                rows_left <= ROWS_LEFT_W'(cmd.count >> BIT_W);
              end
            end
          end
        end
        M_SCAN_RD: begin
          state <= M_SCAN_CHK;
        end
        M_SCAN_CHK: begin
          if (|masked) begin
            done     <= 1'b1;
            hit      <= 1'b1;
            hit_slot <= {row, first};
            state    <= M_IDLE;
          end else if (rows_left == ROWS_LEFT_W'(1)) begin
            done  <= 1'b1;
            hit   <= 1'b0;
            state <= M_IDLE;
          end else begin
            row       <= row + ROW_AW'(1);
            rows_left <= rows_left - ROWS_LEFT_W'(1);
            state     <= M_SCAN_RD;
          end
        end
        M_WR_RD: begin
          state <= M_WR_MOD;
        end
        M_WR_MOD: begin
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

  assign sts.ready    = (state == M_IDLE);
  assign sts.done     = done;
  assign sts.hit      = hit;
  assign sts.hit_slot = hit_slot;

endmodule

// ----- rtl/bpa_ctrl.sv -----
// allocator controller: sequences checks, searches, splits and merges
// depends on bpa_pkg; drives the mark store through mark_cmd_t
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output mark_cmd_t        mcmd,
  input  mark_sts_t        msts
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK,
    S_A_SCAN, S_A_SCAN_W, S_A_CLR, S_A_CLR_W, S_A_SPLIT, S_A_SPLIT_W,
    S_F_ANC, S_F_ANC_W, S_F_DESC, S_F_DESC_W, S_F_BUD, S_F_BUD_W,
    S_F_CLR, S_F_CLR_W, S_F_SET, S_F_SET_W,
    S_DONE
  } state_t;

  state_t             state;
  logic               act;
  logic [ORD_W-1:0]   ord;
  logic [ORD_W-1:0]   cur;
  logic [PAGE_W-1:0]  base;
  logic [SLOT_W-1:0]  hslot;
  status_t            status;
  logic [PAGE_W-1:0]  res_page;
  logic [COUNT_W-1:0] page_count;
  logic [CFG_W-1:0]   sys_pages;
  logic [CFG_W-1:0]   max_request;
  logic [SLOT_W-1:0]  req;
  logic [SLOT_W-1:0]  top;
  logic [COUNT_W:0]   sum;

  localparam logic [ORD_W-1:0] MAX_ORD = ORD_W'(MAX_BLOCK_ORDER);

  assign req = SLOT_W'(1) << ord;
  assign top = SLOT_W'(1) << (MAX_ORD - cur);
  assign sum = (COUNT_W + 1)'(page_count) + (COUNT_W + 1)'(req);
  assign in_ready = (state == S_IDLE) && msts.ready;

  // commands to the mark store
  always_comb begin
    mcmd       = '0;
    mcmd.count = SLOT_W'(1);
    unique case (state)
      S_A_SCAN: begin
        mcmd.valid = 1'b1;
        mcmd.slot  = slot_of(cur, '0);
        mcmd.count = top;
      end
      S_A_CLR, S_F_CLR: begin
        mcmd.valid = 1'b1;
        mcmd.write = 1'b1;
        mcmd.slot  = hslot;
      end
      S_A_SPLIT: begin
        mcmd.valid = 1'b1;
        mcmd.write = 1'b1;
        mcmd.value = 1'b1;
        mcmd.slot  = slot_of(cur, base | (PAGE_W'(1) << cur));
      end
      S_F_ANC: begin
        mcmd.valid = 1'b1;
        mcmd.slot  = slot_of(cur, base);
      end
      S_F_DESC: begin
        mcmd.valid = 1'b1;
        mcmd.slot  = slot_of(cur, base);
        mcmd.count = SLOT_W'(1) << (ord - cur);
      end
      S_F_BUD: begin
        mcmd.valid = (cur != MAX_ORD);
        mcmd.slot  = slot_of(cur, base ^ (PAGE_W'(1) << cur));
      end
      S_F_SET: begin
        mcmd.valid = 1'b1;
        mcmd.write = 1'b1;
        mcmd.value = 1'b1;
        mcmd.slot  = slot_of(cur, base);
      end
      default: begin
        mcmd.valid = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sys_pages   <= CFG_W'(POOL_PAGES);
      max_request <= CFG_W'(POOL_PAGES);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL_PAGES: sys_pages   <= cfg_data;
        CFG_MAX_REQUEST: max_request <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      page_count <= COUNT_W'(POOL_PAGES);
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            act   <= in_item.action;
            ord   <= in_item.order;
            base  <= in_item.page_index & ~((PAGE_W'(1) << in_item.order) - PAGE_W'(1));
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_page <= '0;
          cur      <= ord;
          if (act == ACT_ALLOC) begin
            if (ord > MAX_ORD || req > (sys_pages >> 1) || req > max_request) begin
              status <= ST_REJECT;
              state  <= S_DONE;
            end else begin
              state <= S_A_SCAN;
            end
          end else if (ord > MAX_ORD) begin
            status <= ST_IGNORED;
            state  <= S_DONE;
          end else begin
            state <= S_F_ANC;
          end
        end
        // search orders upward for the lowest free block
        S_A_SCAN:   state <= S_A_SCAN_W;
        S_A_SCAN_W: begin
          if (msts.done) begin
            if (msts.hit) begin
              hslot <= msts.hit_slot;
              base  <= PAGE_W'((msts.hit_slot & (top - SLOT_W'(1))) << cur);
              state <= S_A_CLR;
            end else if (cur == MAX_ORD) begin
              status <= ST_NOMEM;
              state  <= S_DONE;
            end else begin
              cur   <= cur + ORD_W'(1);
              state <= S_A_SCAN;
            end
          end
        end
        S_A_CLR:   state <= S_A_CLR_W;
        S_A_CLR_W, S_A_SPLIT_W: begin
          if (msts.done) begin
            if (cur == ord) begin
              page_count <= (page_count >= req) ? page_count - req : '0;
              res_page   <= base;
              status     <= ST_OK;
              state      <= S_DONE;
            end else begin
              cur   <= cur - ORD_W'(1);
              state <= S_A_SPLIT;
            end
          end
        end
        S_A_SPLIT: state <= S_A_SPLIT_W;
        // overlap check against enclosing blocks
        S_F_ANC:   state <= S_F_ANC_W;
        S_F_ANC_W: begin
          if (msts.done) begin
            if (msts.hit) begin
              status <= ST_IGNORED;
              state  <= S_DONE;
            end else if (cur != MAX_ORD) begin
              cur   <= cur + ORD_W'(1);
              state <= S_F_ANC;
            end else if (ord == '0) begin
              cur   <= ord;
              state <= S_F_BUD;
            end else begin
              cur   <= '0;
              state <= S_F_DESC;
            end
          end
        end
        // overlap check against blocks inside
        S_F_DESC:   state <= S_F_DESC_W;
        S_F_DESC_W: begin
          if (msts.done) begin
            if (msts.hit) begin
              status <= ST_IGNORED;
              state  <= S_DONE;
            end else if (cur == ord - ORD_W'(1)) begin
              cur   <= ord;
              state <= S_F_BUD;
            end else begin
              cur   <= cur + ORD_W'(1);
              state <= S_F_DESC;
            end
          end
        end
        // merge with free buddies
        S_F_BUD: begin
          state <= (cur == MAX_ORD) ? S_F_SET : S_F_BUD_W;
        end
        S_F_BUD_W: begin
          if (msts.done) begin
            hslot <= msts.hit_slot;
            state <= msts.hit ? S_F_CLR : S_F_SET;
          end
        end
        S_F_CLR:   state <= S_F_CLR_W;
        S_F_CLR_W: begin
          if (msts.done) begin
            base  <= base & ~(PAGE_W'(1) << cur);
            cur   <= cur + ORD_W'(1);
            state <= S_F_BUD;
          end
        end
        S_F_SET:   state <= S_F_SET_W;
        S_F_SET_W: begin
          if (msts.done) begin
            page_count <= (sum > (COUNT_W + 1)'(POOL_PAGES)) ?
                          COUNT_W'(POOL_PAGES) : sum[COUNT_W-1:0];
            status     <= ST_OK;
            state      <= S_DONE;
          end
        end
        // hand the result over once the output register is free
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid               <= 1'b1;
            out_item.status         <= status;
            out_item.page_index_res <= res_page;
            out_item.free_count     <= page_count;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cmd_when_ready: assert property (@(posedge clk) disable iff (rst)
    mcmd.valid |-> msts.ready) else $error("mark command while store busy");
  a_page_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_OK |-> out_item.page_index_res == '0)
    else $error("page set on failed item");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second item taken while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    page_count <= COUNT_W'(POOL_PAGES)) else $error("free count above pool size");
`endif

endmodule

// ----- rtl/buddy_page_allocator.sv -----
// buddy page allocator top level: controller plus mark store
// depends on bpa_pkg, bpa_ctrl and bpa_marks
//
// channel   signals                         direction
// in        in_valid, in_ready, in_item     item in (alloc or free)
// out       out_valid, out_ready, out_item  one result item per input item
// cfg       cfg_we, cfg_index, cfg_data     register write, no wait
//
// one item at a time; marks live in a 64 x 32 ram, and a mark command that scans
// a range reads its rows in turn until a mark is found
// alloc: one scan per order searched, one clear, then one mark write per split
// free: one scan per overlap level (32 rows at order 0), then a buddy scan and a clear per merge
// after reset a clearing pass over all 64 rows runs before the first item is taken
// a waiting result holds the controller until it is taken
module buddy_page_allocator
  import bpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  mark_cmd_t mcmd;
  mark_sts_t msts;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .mcmd     (mcmd),
    .msts     (msts)
  );

  bpa_marks u_marks (
    .clk(clk),
    .rst(rst),
    .cmd(mcmd),
    .sts(msts)
  );

endmodule
